@@ rtl/core/scsa_pkg.sv @@
// scsa_pkg: shared types, codes and constants of the size class segment allocator
// used by every module under rtl/core; depends on nothing
`default_nettype none

package scsa_pkg;

   localparam int NUM_CLASSES     = 4;
   localparam int CLS_W           = 2;
   localparam int SIZE_W          = 16;
   localparam int CNT_W           = 7;
   localparam int SLOT_W          = 6;
   localparam int STRIDE_W        = SIZE_W + 1;
   localparam int SEG_HDR_BYTES   = 8;
   localparam int EVENT_HDR_BYTES = 16;
   localparam int DEPTH_MIN       = 3;
   localparam int CNT_MAX         = 127;
   localparam int CSR_IDX_W       = 3;
   localparam int CSR_DATA_W      = 16;

   localparam logic [1:0] FUNC_ALLOC = 2'd0;
   localparam logic [1:0] FUNC_FREE  = 2'd1;
   localparam logic [1:0] FUNC_DEPTH = 2'd2;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_NO_FIT   = 2'd1;
   localparam logic [1:0] STATUS_BAD_FREE = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_CLASS_SIZE_0  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CLASS_COUNT_0 = 3'd4;

   typedef struct packed {
      logic [1:0]        func;
      logic [SIZE_W-1:0] req_size;
      logic [CLS_W-1:0]  free_class;
      logic [SLOT_W-1:0] free_slot;
   } req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [CLS_W-1:0]  seg_class;
      logic [SLOT_W-1:0] seg_slot;
      logic [SIZE_W-1:0] payload_offset;
      logic              depth_ok;
      logic [CNT_W-1:0]  in_use;
      logic [CNT_W-1:0]  peak_use;
   } rsp_type;

   typedef logic [NUM_CLASSES-1:0][SIZE_W-1:0] size_vec_type;
   typedef logic [NUM_CLASSES-1:0][CNT_W-1:0]  count_vec_type;

   typedef enum logic {
      S_IDLE,
      S_RESOLVE
   } state_type;

endpackage

`default_nettype wire

@@ rtl/core/scsa_ring.sv @@
// scsa_ring: free slot ring memory, one write and one registered read per cycle
// entries never written read back as their position within the class; uses scsa_pkg
`default_nettype none

module scsa_ring
   import scsa_pkg::*;
#(
   parameter int HEAD_W = 6,
   parameter int ENT_W  = 6
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      rd_en,
   input  wire logic [CLS_W+HEAD_W-1:0]   rd_addr,
   output logic      [ENT_W-1:0]          rd_data,
   input  wire logic                      wr_en,
   input  wire logic [CLS_W+HEAD_W-1:0]   wr_addr,
   input  wire logic [ENT_W-1:0]          wr_data
);

   localparam int ADDR_W = CLS_W + HEAD_W;
   localparam int DEPTH  = 2 ** ADDR_W;

   logic [ENT_W-1:0] mem [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   logic [ENT_W-1:0] rd_q_ff;
   logic [ENT_W-1:0] rd_dflt_ff;
   logic             rd_vld_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_q_ff    <= mem[rd_addr];
         rd_dflt_ff <= ENT_W'(rd_addr[HEAD_W-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_vld_ff <= valid_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_vld_ff ? rd_q_ff : rd_dflt_ff;

endmodule

`default_nettype wire

@@ rtl/core/scsa_layout.sv @@
// scsa_layout: walks the classes after a config write and rebuilds the byte base of each class
// one class per cycle through a single multiply-add; uses scsa_pkg
`default_nettype none

module scsa_layout
   import scsa_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire size_vec_type  size_vec,
   input  wire count_vec_type eff_vec,
   output logic               busy,
   output size_vec_type       base_vec
);

   localparam int PROD_W = CNT_W + STRIDE_W;

   logic              busy_ff, busy_in;
   logic [CLS_W-1:0]  idx_ff, idx_in;
   logic [SIZE_W-1:0] acc_ff, acc_in;
   size_vec_type      base_ff, base_in;

   logic [PROD_W-1:0] prod;
   logic [SIZE_W-1:0] sum;

   always_comb begin
      prod    = PROD_W'(eff_vec[idx_ff]) *
                PROD_W'(STRIDE_W'(SEG_HDR_BYTES) + STRIDE_W'(size_vec[idx_ff]));
      sum     = acc_ff + prod[SIZE_W-1:0];
      busy_in = busy_ff;
      idx_in  = idx_ff;
      acc_in  = acc_ff;
      base_in = base_ff;
      if (start) begin
         busy_in = 1'b1;
         idx_in  = '0;
         acc_in  = '0;
      end else if (busy_ff) begin
         base_in[CLS_W'(idx_ff + 1'b1)] = sum;
         acc_in = sum;
         idx_in = CLS_W'(idx_ff + 1'b1);
         if (idx_ff == CLS_W'(NUM_CLASSES - 2)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
         acc_ff  <= '0;
         base_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
         acc_ff  <= acc_in;
         base_ff <= base_in;
      end
   end

   assign busy     = busy_ff;
   assign base_vec = base_ff;

endmodule

`default_nettype wire

@@ rtl/core/size_class_segment_allocator_unit.sv @@
// size_class_segment_allocator_unit: top level, class counters, request sequencing, result register
// instantiates scsa_ring and scsa_layout; uses scsa_pkg
`default_nettype none

// An allocate, free or depth check is taken in S_IDLE and finished in S_RESOLVE: the transfer
// cycle picks the class, updates its head, free count, in-use and peak counters and issues the
// free ring memory access; S_RESOLVE takes the ring read data and forms the payload offset with
// one multiply-add into the result register once that register is free, so a stalled result
// holds the next item in S_RESOLVE and no new request is taken. After each config write
// req_ready is low while the class base offsets are rebuilt. The ring needs no clearing pass
// after reset: unwritten entries read as their slot position.
module size_class_segment_allocator_unit
   import scsa_pkg::*;
#(
   parameter int MAX_SEGS = 64
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire req_type               req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output rsp_type                    rsp_data,
   input  wire logic                  csr_write_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_write_data
);

   localparam int HEAD_W  = (MAX_SEGS > 1) ? $clog2(MAX_SEGS) : 1;
   localparam int ENT_W   = (HEAD_W > SLOT_W) ? HEAD_W : SLOT_W;
   localparam int ADDR_W  = CLS_W + HEAD_W;
   localparam int CMP_W   = CNT_W + 2;
   localparam int SUM_W   = ((HEAD_W > CNT_W) ? HEAD_W : CNT_W) + 1;
   localparam int DSUM_W  = CNT_W + CLS_W;
   localparam int OPROD_W = ENT_W + STRIDE_W;

   state_type         state_ff, state_in;
   size_vec_type      size_ff, size_in;
   count_vec_type     count_ff, count_in;
   logic [HEAD_W-1:0] head_ff [NUM_CLASSES];
   logic [HEAD_W-1:0] head_in [NUM_CLASSES];
   count_vec_type     fcnt_ff, fcnt_in;
   count_vec_type     use_ff, use_in;
   count_vec_type     peak_ff, peak_in;

   rsp_type             pend_ff, pend_in;
   logic                hit_ff, hit_in;
   logic [STRIDE_W-1:0] stride_ff, stride_in;
   logic [SIZE_W-1:0]   basehdr_ff, basehdr_in;
   rsp_type             rsp_ff, rsp_in;
   logic                rsp_valid_ff, rsp_valid_in;

   count_vec_type     eff;
   size_vec_type      base_vec;
   logic              layout_busy;
   logic              accept;

   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [ENT_W-1:0]  rd_data;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;

   logic [OPROD_W-1:0] oprod;
   rsp_type            res;

   scsa_ring #(
      .HEAD_W (HEAD_W),
      .ENT_W  (ENT_W)
   ) u_ring (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (ENT_W'(req_data.free_slot))
   );

   scsa_layout u_layout (
      .clock    (clock),
      .reset    (reset),
      .start    (csr_write_en),
      .size_vec (size_ff),
      .eff_vec  (eff),
      .busy     (layout_busy),
      .base_vec (base_vec)
   );

   always_comb begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
         eff[c] = ({2'b00, count_ff[c]} > CMP_W'(MAX_SEGS)) ? CNT_W'(MAX_SEGS) : count_ff[c];
      end
   end

   assign req_ready = (state_ff == S_IDLE) && !layout_busy;
   assign accept    = req_valid && req_ready;

   // offset and slot of an allocate arrive with the ring read data
   always_comb begin
      oprod = OPROD_W'(rd_data) * OPROD_W'(stride_ff);
      res   = pend_ff;
      if (hit_ff) begin
         res.seg_slot       = rd_data[SLOT_W-1:0];
         res.payload_offset = basehdr_ff + oprod[SIZE_W-1:0];
      end
   end

   always_comb begin
      logic              a_hit;
      logic [CLS_W-1:0]  a_cls;
      logic [CLS_W-1:0]  fc;
      logic [CLS_W-1:0]  t_cls;
      logic              slot_ok;
      logic              push_ok;
      logic [SUM_W-1:0]  tail_sum;
      logic [CNT_W-1:0]  use_nxt;
      logic [SIZE_W:0]   need;
      logic [DSUM_W-1:0] dsum;
      logic [CLS_W-1:0]  wc;
      logic [CNT_W-1:0]  new_cnt;
      logic [CNT_W-1:0]  new_eff;

      state_in     = state_ff;
      size_in      = size_ff;
      count_in     = count_ff;
      head_in      = head_ff;
      fcnt_in      = fcnt_ff;
      use_in       = use_ff;
      peak_in      = peak_ff;
      pend_in      = pend_ff;
      hit_in       = hit_ff;
      stride_in    = stride_ff;
      basehdr_in   = basehdr_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rd_en        = 1'b0;
      wr_en        = 1'b0;

      // allocate: first class that fits and has a free slot
      a_hit = 1'b0;
      a_cls = '0;
      for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
         if (req_data.req_size <= size_ff[c] && fcnt_ff[c] != '0 && eff[c] != '0) begin
            a_hit = 1'b1;
            a_cls = CLS_W'(c);
         end
      end
      rd_addr = {a_cls, head_ff[a_cls]};
      use_nxt = (use_ff[a_cls] == CNT_W'(CNT_MAX)) ? use_ff[a_cls]
                                                   : CNT_W'(use_ff[a_cls] + 1'b1);

      // free: lowest enabled class of equal size takes the slot
      fc      = req_data.free_class;
      slot_ok = (eff[fc] != '0) && (CNT_W'(req_data.free_slot) < eff[fc]);
      t_cls   = fc;
      for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
         if (CLS_W'(c) < fc && eff[c] != '0 && size_ff[c] == size_ff[fc]) begin
            t_cls = CLS_W'(c);
         end
      end
      push_ok  = (fcnt_ff[t_cls] < eff[t_cls]) && (use_ff[t_cls] != '0);
      tail_sum = SUM_W'(head_ff[t_cls]) + SUM_W'(fcnt_ff[t_cls]);
      if (tail_sum >= SUM_W'(eff[t_cls])) begin
         tail_sum = tail_sum - SUM_W'(eff[t_cls]);
      end
      wr_addr = {t_cls, tail_sum[HEAD_W-1:0]};

      // depth check
      need = (SIZE_W + 1)'(req_data.req_size) + (SIZE_W + 1)'(EVENT_HDR_BYTES);
      dsum = '0;
      for (int c = 0; c < NUM_CLASSES; c++) begin
         if ({1'b0, size_ff[c]} >= need) begin
            dsum = dsum + DSUM_W'(fcnt_ff[c]);
         end
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               pend_in  = '0;
               hit_in   = 1'b0;
               state_in = S_RESOLVE;
               case (req_data.func)
                  FUNC_ALLOC: begin
                     if (a_hit) begin
                        rd_en  = 1'b1;
                        hit_in = 1'b1;
                        if (CMP_W'(head_ff[a_cls]) + 1'b1 == CMP_W'(eff[a_cls])) begin
                           head_in[a_cls] = '0;
                        end else begin
                           head_in[a_cls] = HEAD_W'(head_ff[a_cls] + 1'b1);
                        end
                        fcnt_in[a_cls] = CNT_W'(fcnt_ff[a_cls] - 1'b1);
                        use_in[a_cls]  = use_nxt;
                        peak_in[a_cls] = (use_nxt > peak_ff[a_cls]) ? use_nxt : peak_ff[a_cls];
                        pend_in.status    = STATUS_OK;
                        pend_in.seg_class = a_cls;
                        pend_in.in_use    = use_nxt;
                        pend_in.peak_use  = (use_nxt > peak_ff[a_cls]) ? use_nxt
                                                                        : peak_ff[a_cls];
                        stride_in  = STRIDE_W'(SEG_HDR_BYTES) + STRIDE_W'(size_ff[a_cls]);
                        basehdr_in = base_vec[a_cls] + SIZE_W'(SEG_HDR_BYTES);
                     end else begin
                        pend_in.status = STATUS_NO_FIT;
                     end
                  end
                  FUNC_FREE: begin
                     pend_in.status    = STATUS_BAD_FREE;
                     pend_in.seg_class = fc;
                     pend_in.seg_slot  = req_data.free_slot;
                     pend_in.in_use    = use_ff[fc];
                     pend_in.peak_use  = peak_ff[fc];
                     if (slot_ok) begin
                        pend_in.seg_class = t_cls;
                        pend_in.in_use    = use_ff[t_cls];
                        pend_in.peak_use  = peak_ff[t_cls];
                        if (push_ok) begin
                           wr_en          = 1'b1;
                           fcnt_in[t_cls] = CNT_W'(fcnt_ff[t_cls] + 1'b1);
                           use_in[t_cls]  = CNT_W'(use_ff[t_cls] - 1'b1);
                           pend_in.status = STATUS_OK;
                           pend_in.in_use = CNT_W'(use_ff[t_cls] - 1'b1);
                        end
                     end
                  end
                  FUNC_DEPTH: begin
                     pend_in.depth_ok = (dsum >= DSUM_W'(DEPTH_MIN));
                  end
                  default: begin
                     pend_in.status = STATUS_OK;
                  end
               endcase
            end
         end
         S_RESOLVE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in       = res;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // config write reloads head and free count of the class concerned
      wc      = csr_index[CLS_W-1:0];
      new_cnt = count_ff[wc];
      if (csr_index >= CSR_CLASS_COUNT_0) begin
         new_cnt = csr_write_data[CNT_W-1:0];
      end
      new_eff = ({2'b00, new_cnt} > CMP_W'(MAX_SEGS)) ? CNT_W'(MAX_SEGS) : new_cnt;
      if (csr_write_en) begin
         if (csr_index < CSR_CLASS_COUNT_0) begin
            size_in[CLS_W'(csr_index - CSR_CLASS_SIZE_0)] = csr_write_data[SIZE_W-1:0];
         end else begin
            count_in[wc] = new_cnt;
         end
         head_in[wc] = '0;
         fcnt_in[wc] = new_eff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         size_ff      <= '0;
         count_ff     <= '0;
         fcnt_ff      <= '0;
         use_ff       <= '0;
         peak_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int c = 0; c < NUM_CLASSES; c++) begin
            head_ff[c] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         size_ff      <= size_in;
         count_ff     <= count_in;
         head_ff      <= head_in;
         fcnt_ff      <= fcnt_in;
         use_ff       <= use_in;
         peak_ff      <= peak_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff    <= pend_in;
      hit_ff     <= hit_in;
      stride_ff  <= stride_in;
      basehdr_ff <= basehdr_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_accept_not_during_layout: assert property (@(posedge clock) disable iff (reset)
      accept |-> !layout_busy && state_ff == S_IDLE)
      else $error("request transfer while class layout rebuild or item in flight");

   a_accept_then_resolve: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == S_RESOLVE)
      else $error("accepted request did not move to resolve");

   a_free_count_bound: assert property (@(posedge clock) disable iff (reset)
      fcnt_ff[0] <= eff[0])
      else $error("class 0 free count above its segment count");

   a_head_bound: assert property (@(posedge clock) disable iff (reset)
      eff[0] != '0 |-> CMP_W'(head_ff[0]) < CMP_W'(eff[0]))
      else $error("class 0 ring head beyond its segment count");

   a_peak_covers_use: assert property (@(posedge clock) disable iff (reset)
      peak_ff[0] >= use_ff[0])
      else $error("class 0 peak below in-use count");
`endif

endmodule

`default_nettype wire
